// ----- hw/rtl/rcbp_pkg.sv -----
`default_nettype none

package rcbp_pkg;

  localparam int unsigned NUM_BUFFERS_DEF = 256;
  localparam int unsigned MAX_BATCH_DEF   = 16;

  localparam int unsigned CNT_BITS = 16;
  localparam logic [CNT_BITS-1:0] REF_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ACQUIRE = 2'd0,
    OP_ADD_REF = 2'd1,
    OP_RELEASE = 2'd2,
    OP_RSVD    = 2'd3
  } rcbp_op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_LIMIT   = 2'd2;
  localparam logic [1:0] ST_REFUSED = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] buffer_id;
    logic [4:0] count;
  } rcbp_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] granted_id;
    logic       freed;
    logic       last;
  } rcbp_out_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rcbp_ram.sv -----
`default_nettype none

module rcbp_ram #(
  parameter int unsigned WIDTH = 25,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/rcbp_out_reg.sv -----
`default_nettype none

module rcbp_out_reg
  import rcbp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      load,
  input  wire rcbp_out_t load_data,
  output logic           can_load,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rcbp_out_t      out_data
);

  logic      valid_r, valid_nxt;
  rcbp_out_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/rcbp_engine.sv -----
`default_nettype none

module rcbp_engine
  import rcbp_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF,
  parameter int unsigned MAX_BATCH   = MAX_BATCH_DEF,
  parameter int unsigned ID_W        = $clog2(NUM_BUFFERS),
  parameter int unsigned ENT_W       = ID_W + 1 + CNT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire rcbp_in_t         in_data,
  input  wire logic             res_can_load,
  output logic                  res_valid,
  output rcbp_out_t             res,
  output logic                  ram_we,
  output logic [ID_W-1:0]       ram_waddr,
  output logic [ENT_W-1:0]      ram_wdata,
  output logic                  ram_re,
  output logic [ID_W-1:0]       ram_raddr,
  input  wire logic [ENT_W-1:0] ram_rdata
);

  localparam int unsigned CNT_W = $clog2(NUM_BUFFERS + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  rcbp_in_t          item_r, item_nxt;
  logic [4:0]        rem_r, rem_nxt;
  logic              first_r, first_nxt;
  logic [ID_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  // ids below the watermark were never handed out: link is id-1, count 0
  logic [CNT_W-1:0]  wm_r, wm_nxt;

  logic [ID_W-1:0]     id_a, tgt, next_head, ent_link;
  logic                id_ok, stale, use_v, ent_use;
  logic [CNT_BITS-1:0] cnt_v, ent_cnt;

  assign ent_link = ram_rdata[ENT_W-1 -: ID_W];
  assign ent_use  = ram_rdata[CNT_BITS];
  assign ent_cnt  = ram_rdata[CNT_BITS-1:0];

  assign id_a  = ID_W'(item_r.buffer_id);
  assign id_ok = {24'd0, item_r.buffer_id} < 32'(NUM_BUFFERS);
  assign tgt   = (item_r.op == OP_ACQUIRE) ? head_r : id_a;
  assign stale = CNT_W'(tgt) < wm_r;
  assign use_v = !stale && ent_use;
  assign cnt_v = stale ? '0 : ent_cnt;

  assign next_head = !stale ? ent_link :
                     (head_r == '0) ? '0 : head_r - ID_W'(1);

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    item_nxt   = item_r;
    rem_nxt    = rem_r;
    first_nxt  = first_r;
    head_nxt   = head_r;
    total_nxt  = total_r;
    wm_nxt     = wm_r;
    ram_re     = 1'b0;
    ram_raddr  = head_r;
    ram_we     = 1'b0;
    ram_waddr  = tgt;
    ram_wdata  = '0;
    res_valid  = 1'b0;
    res        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt  = in_data;
          rem_nxt   = in_data.count;
          first_nxt = 1'b1;
          ram_re    = 1'b1;
          ram_raddr = (in_data.op == OP_ACQUIRE) ? head_r : ID_W'(in_data.buffer_id);
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (res_can_load) begin
          res_valid      = 1'b1;
          res.status     = ST_OK;
          res.granted_id = item_r.buffer_id;
          res.freed      = 1'b0;
          res.last       = 1'b1;
          state_nxt      = S_IDLE;
          if (item_r.op == OP_ACQUIRE) begin
            if (first_r && (item_r.count == '0 ||
                            32'(item_r.count) > 32'(MAX_BATCH))) begin
              res.status     = ST_INVALID;
              res.granted_id = '0;
            end else if (first_r && 32'(item_r.count) > 32'(total_r)) begin
              res.status     = ST_LIMIT;
              res.granted_id = '0;
            end else begin
              // pop one buffer; the next head read, if more remain, overlaps with this write
              ram_we         = 1'b1;
              ram_waddr      = head_r;
              ram_wdata      = {{ID_W{1'b0}}, 1'b1, CNT_BITS'(1)};
              head_nxt       = next_head;
              total_nxt      = total_r - CNT_W'(1);
              if (stale) begin
                wm_nxt = CNT_W'(head_r);
              end
              rem_nxt        = rem_r - 5'd1;
              first_nxt      = 1'b0;
              res.granted_id = 8'(head_r);
              res.last       = (rem_r == 5'd1);
              if (rem_r != 5'd1) begin
                ram_re    = 1'b1;
                ram_raddr = next_head;
                state_nxt = S_EXEC;
              end
            end
          end else if (item_r.op == OP_RSVD || !id_ok) begin
            res.status = ST_INVALID;
          end else if (item_r.op == OP_ADD_REF) begin
            if (!use_v || cnt_v == REF_MAX) begin
              res.status = ST_REFUSED;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {ent_link, 1'b1, cnt_v + CNT_BITS'(1)};
            end
          end else begin
            if (!use_v || cnt_v == '0) begin
              res.status = ST_REFUSED;
            end else if (cnt_v == CNT_BITS'(1)) begin
              // last reference gone: push on the free list head
              ram_we    = 1'b1;
              ram_wdata = {head_r, 1'b0, {CNT_BITS{1'b0}}};
              head_nxt  = id_a;
              total_nxt = total_r + CNT_W'(1);
              res.freed = 1'b1;
            end else begin
              ram_we    = 1'b1;
              ram_wdata = {ent_link, 1'b1, cnt_v - CNT_BITS'(1)};
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      head_r  <= ID_W'(NUM_BUFFERS - 1);
      total_r <= CNT_W'(NUM_BUFFERS);
      wm_r    <= CNT_W'(NUM_BUFFERS);
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      head_r  <= head_nxt;
      total_r <= total_nxt;
      wm_r    <= wm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
    rem_r  <= rem_nxt;
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(total_r) <= 32'(NUM_BUFFERS))
    else $error("free count above pool size");

  a_wm_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wm_r <= total_r)
    else $error("untouched ids exceed free count");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && item_r.op == OP_ACQUIRE) |-> total_r != '0)
    else $error("pop from empty free list");

  a_rw_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> ram_waddr != ram_raddr)
    else $error("read and write collide on one entry");

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_EXEC)
    else $error("accepted word not executed");

endmodule

`default_nettype wire

// ----- hw/rtl/refcounted_buffer_pool.sv -----
// Flow: each word reads its entry, then executes; the next word waits until
//   it is done. A ref, release or failed acquire gives one result word; an acquire
//   of n buffers gives n, one free-list pop per cycle unless the output stalls.
// Reset: rst_n synchronous, active low; the pool is usable the cycle after reset,
//   with no memory clearing pass (a watermark marks never-used entries).
`default_nettype none

module refcounted_buffer_pool
  import rcbp_pkg::*;
#(
  parameter int unsigned NUM_BUFFERS = NUM_BUFFERS_DEF,
  parameter int unsigned MAX_BATCH   = MAX_BATCH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire rcbp_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output rcbp_out_t      out_data
);

  // one entry per buffer: {free-list link, in-use mark, reference count}
  localparam int unsigned ID_W  = $clog2(NUM_BUFFERS);
  localparam int unsigned ENT_W = ID_W + 1 + CNT_BITS;

  logic             ram_we, ram_re;
  logic [ID_W-1:0]  ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic      res_valid, res_can_load;
  rcbp_out_t res;

  // entry memory, registered read
  rcbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_BUFFERS),
    .AW    (ID_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read-modify-write sequencer: free-list head, free count, watermark
  rcbp_engine #(
    .NUM_BUFFERS (NUM_BUFFERS),
    .MAX_BATCH   (MAX_BATCH),
    .ID_W        (ID_W),
    .ENT_W       (ENT_W)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .res_can_load (res_can_load),
    .res_valid    (res_valid),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // output word register; lets the engine take a new word while a result waits
  rcbp_out_reg u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res),
    .can_load  (res_can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

// Testbench for refcounted_buffer_pool.
//
// A clocked driver feeds input words from pending_words; an initial block
// fills that queue, a few words ahead of the driver. Each accepted word goes
// through apply_pool_op, which keeps a private copy of the free list, the
// reference counts and the in-use marks. It queues the result words that the
// pool must produce in due_words. A clocked monitor pops the oldest entry for
// each result word accepted and compares it field by field.
//
// Stimulus runs in phases:
//   directed  - bad counts, reserved op, ref/release of free buffers,
//               LIFO reuse after a free, batch of MAX_BATCH
//   mixed     - random acquire/ref/release on live ids, plus noise
//   fill      - exhaust the pool, then hit the not-enough-free case, both with
//               some buffers left and with none left
//   mixed     - release-heavy random traffic
//   drain     - release every live buffer until the pool is full again
//   mixed     - a short random tail on the refilled pool
// Both sides idle at random, except during the drain phase, which runs flat out.

module tb_top;
  import rcbp_pkg::*;

  localparam int CLK_PERIOD     = 4;
  localparam int NUM_BUFFERS    = NUM_BUFFERS_DEF;
  localparam int MAX_BATCH      = MAX_BATCH_DEF;
  localparam int IDLE_PCT       = 17;
  localparam int LOOKAHEAD      = 4;     // words queued ahead of the driver
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
  localparam int TAIL_CYCLES    = 16;    // wait after the last result word

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  rcbp_in_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  rcbp_out_t out_data;

  refcounted_buffer_pool dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow pool state, advanced once per accepted input word.
  logic [7:0]  pool_link [NUM_BUFFERS];
  logic [15:0] pool_refs [NUM_BUFFERS];
  bit          pool_in_use [NUM_BUFFERS];
  logic [7:0]  pool_head;
  int          pool_free;

  rcbp_in_t  pending_words [$];
  rcbp_out_t due_words [$];
  rcbp_out_t want_word;
  int        words_queued = 0;
  int        words_taken  = 0;
  int        err_count    = 0;
  int        quiet_cycles = 0;
  bit        calm         = 1'b0;  // set: neither side idles

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Expected result words for one accepted input word.
  task automatic apply_pool_op(input rcbp_in_t w);
    rcbp_out_t  r;
    logic [7:0] b;
    int         k;
    r = '0;
    r.last = 1'b1;
    r.granted_id = w.buffer_id;
    if (w.op == OP_ACQUIRE) begin
      r.granted_id = '0;
      if (w.count == 0 || w.count > MAX_BATCH) begin
        r.status = ST_INVALID;
      end else if (int'(w.count) > pool_free) begin
        r.status = ST_LIMIT;
      end else begin
        // pop from the head, one result word per buffer
        for (k = 0; k < w.count; k++) begin
          b = pool_head;
          pool_head = pool_link[b];
          pool_free--;
          pool_refs[b] = 16'd1;
          pool_in_use[b] = 1'b1;
          r.status = ST_OK;
          r.granted_id = b;
          r.last = (k == w.count - 1);
          due_words.push_back(r);
        end
        return;
      end
    end else if (w.op == OP_RSVD || int'(w.buffer_id) >= NUM_BUFFERS) begin
      r.status = ST_INVALID;
    end else if (w.op == OP_ADD_REF) begin
      if (!pool_in_use[w.buffer_id] || pool_refs[w.buffer_id] == REF_MAX) begin
        r.status = ST_REFUSED;
      end else begin
        pool_refs[w.buffer_id]++;
        r.status = ST_OK;
      end
    end else begin
      if (!pool_in_use[w.buffer_id] || pool_refs[w.buffer_id] == 0) begin
        r.status = ST_REFUSED;
      end else begin
        pool_refs[w.buffer_id]--;
        r.status = ST_OK;
        if (pool_refs[w.buffer_id] == 0) begin
          // last reference gone: buffer goes back on the head
          pool_in_use[w.buffer_id] = 1'b0;
          pool_link[w.buffer_id] = pool_head;
          pool_head = w.buffer_id;
          if (pool_free < NUM_BUFFERS) pool_free++;
          r.freed = 1'b1;
        end
      end
    end
    due_words.push_back(r);
  endtask

  // Driver: valid holds with a stable word until the pool takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        words_taken++;
        apply_pool_op(in_data);
      end
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_data <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result word %p", out_data));
        end else begin
          want_word = due_words.pop_front();
          if (out_data.status !== want_word.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      out_data.status, want_word.status));
          if (out_data.granted_id !== want_word.granted_id)
            report_mismatch($sformatf("granted_id %0d, want %0d",
                                      out_data.granted_id, want_word.granted_id));
          if (out_data.freed !== want_word.freed)
            report_mismatch($sformatf("freed %0b, want %0b (id %0d)",
                                      out_data.freed, want_word.freed,
                                      want_word.granted_id));
          if (out_data.last !== want_word.last)
            report_mismatch($sformatf("last %0b, want %0b (id %0d)",
                                      out_data.last, want_word.last,
                                      want_word.granted_id));
        end
      end
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: any handshake on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", quiet_cycles);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_word(input rcbp_op_t op, input logic [7:0] id,
                            input logic [4:0] cnt);
    rcbp_in_t w;
    w.op = op;
    w.buffer_id = id;
    w.count = cnt;
    while (pending_words.size() >= LOOKAHEAD) @(posedge clk);
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Every queued word taken and every result word seen.
  task automatic wait_drained();
    while (words_taken != words_queued || due_words.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_live_id();
    logic [7:0] ids [$];
    for (int i = 0; i < NUM_BUFFERS; i++)
      if (pool_in_use[i]) ids.push_back(8'(i));
    if (ids.size() == 0) return 8'($urandom_range(255));
    return ids[$urandom_range(ids.size() - 1)];
  endfunction

  function automatic logic [4:0] batch_size();
    if ($urandom_range(3) != 0) return 5'($urandom_range(4, 1));
    return 5'($urandom_range(MAX_BATCH, 1));
  endfunction

  // One random word; weights in percent for acquire, ref, release, rest noise.
  task automatic queue_random_word(input int acq_pct, input int ref_pct,
                                   input int rel_pct);
    int pick;
    pick = $urandom_range(99);
    if (pick < acq_pct)
      queue_word(OP_ACQUIRE, 8'($urandom_range(255)), batch_size());
    else if (pick < acq_pct + ref_pct)
      queue_word(OP_ADD_REF, pick_live_id(), 5'($urandom_range(31)));
    else if (pick < acq_pct + ref_pct + rel_pct)
      queue_word(OP_RELEASE, pick_live_id(), 5'($urandom_range(31)));
    else
      queue_word(rcbp_op_t'($urandom_range(3)), 8'($urandom_range(255)),
                 5'($urandom_range(31)));
  endtask

  initial begin : stimulus
    int         n;
    int         guard;
    int         left;

    for (n = 0; n < NUM_BUFFERS; n++) begin
      pool_link[n] = (n == 0) ? 8'd0 : 8'(n - 1);
      pool_refs[n] = '0;
      pool_in_use[n] = 1'b0;
    end
    pool_head = 8'(NUM_BUFFERS - 1);
    pool_free = NUM_BUFFERS;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed
    queue_word(OP_ACQUIRE, 8'h00, 5'd0);
    queue_word(OP_ACQUIRE, 8'h00, 5'(MAX_BATCH + 1));
    queue_word(OP_ACQUIRE, 8'hFF, 5'h1F);
    queue_word(OP_RSVD,    8'hA5, 5'd5);
    queue_word(OP_ADD_REF, 8'h00, 5'd0);      // ref of a free buffer
    queue_word(OP_RELEASE, 8'hFF, 5'd0);      // release of a free buffer
    queue_word(OP_ACQUIRE, 8'h00, 5'd1);
    queue_word(OP_ACQUIRE, 8'h00, 5'(MAX_BATCH));
    queue_word(OP_ADD_REF, 8'hFF, 5'd0);
    queue_word(OP_RELEASE, 8'hFF, 5'd0);      // count 2 -> 1
    queue_word(OP_RELEASE, 8'hFF, 5'd0);      // back on the free list
    queue_word(OP_RELEASE, 8'hFF, 5'd0);      // already free
    queue_word(OP_ADD_REF, 8'hFF, 5'd0);
    queue_word(OP_ACQUIRE, 8'h00, 5'd1);      // LIFO: same id again
    queue_word(OP_RELEASE, 8'd239, 5'h1F);
    queue_word(OP_RELEASE, 8'd240, 5'h10);
    queue_word(OP_ACQUIRE, 8'h5A, 5'd2);
    queue_word(OP_RSVD,    8'h00, 5'd0);
    queue_word(OP_ACQUIRE, 8'hFF, 5'(MAX_BATCH));

    // sender holds off until all results are back
    wait_drained();

    for (n = 0; n < 30; n++) queue_random_word(40, 20, 25);

    // exhaust the pool
    guard = 0;
    while (pool_free >= MAX_BATCH && guard < 40) begin
      queue_word(OP_ACQUIRE, 8'($urandom_range(255)), 5'(MAX_BATCH));
      guard++;
    end
    wait_drained();
    left = pool_free;
    queue_word(OP_ACQUIRE, 8'($urandom_range(255)), 5'(left + 1));
    if (left > 0) queue_word(OP_ACQUIRE, 8'($urandom_range(255)), 5'(left));
    queue_word(OP_ACQUIRE, 8'($urandom_range(255)), 5'd1);
    queue_word(OP_ADD_REF, pick_live_id(), 5'($urandom_range(31)));

    for (n = 0; n < 30; n++) queue_random_word(25, 20, 40);

    // give everything back, no idling on either side
    calm = 1'b1;
    guard = 0;
    while (pool_free < NUM_BUFFERS && guard < 1500) begin
      queue_word(OP_RELEASE, pick_live_id(), 5'($urandom_range(31)));
      guard++;
      if (guard % 8 == 0) wait_drained();
    end
    wait_drained();
    calm = 1'b0;

    for (n = 0; n < 10; n++) queue_random_word(35, 20, 30);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/rcbp_pkg.sv
hw/rtl/rcbp_ram.sv
hw/rtl/rcbp_out_reg.sv
hw/rtl/rcbp_engine.sv
hw/rtl/refcounted_buffer_pool.sv
dv/tb_top.sv
